// ===== hdl/wpap_pkg.sv =====
`default_nettype none

package wpap_pkg;

    // waveform geometry
    localparam int SAMPLES_PER_CHANNEL = 2560;
    localparam int NUM_CHANNELS        = 4;
    localparam int NUM_CELLS           = 128;

    // field widths
    localparam int CH_W     = 2;
    localparam int IDX_W    = 12;
    localparam int RAW_W    = 16;
    localparam int ADC_W    = 12;
    localparam int CELL_W   = 8;
    localparam int VERN_W   = 16;
    localparam int VAL_W    = 13;
    localparam int SLOPE_W  = 24;
    localparam int OFFSET_W = 32;
    localparam int FRAC_W   = 16;

    // stream and config port widths
    localparam int S_TDATA_W = 56;
    localparam int S_TUSER_W = 2;
    localparam int M_TDATA_W = 32;
    localparam int M_TUSER_W = 1;
    localparam int CFG_AW    = 1;
    localparam int CFG_DW    = 32;

    // pedestal memory
    localparam int MEM_DEPTH = NUM_CHANNELS * SAMPLES_PER_CHANNEL;
    localparam int MEM_AW    = $clog2(MEM_DEPTH);

    // shift arithmetic
    localparam int COARSE_STEP = SAMPLES_PER_CHANNEL / NUM_CELLS;
    localparam int PROD_W      = SLOPE_W + VERN_W;
    localparam int SUM_W       = PROD_W + 1;
    localparam int FINE_W      = SUM_W - FRAC_W;
    localparam int TOTAL_W     = FINE_W + 1;
    localparam int COARSE_W    = 13;
    localparam int CDIFF_W     = CELL_W + 2;

    // the channel length splits as 5 * 2**SHIFT_LOW_W
    localparam int SHIFT_LOW_W = 9;
    localparam int QUOT_W      = TOTAL_W - SHIFT_LOW_W;
    localparam int QBIAS_W     = QUOT_W + 1;
    // multiple of five that makes the block quotient non-negative
    localparam int QBIAS       = 65540;

    typedef enum logic [S_TUSER_W-1:0] {
        OP_PEDESTAL = 2'd0,
        OP_START    = 2'd1,
        OP_SAMPLE   = 2'd2
    } op_t;

    typedef enum logic [M_TUSER_W-1:0] {
        KIND_SAMPLE = 1'b0,
        KIND_PEAK   = 1'b1
    } kind_t;

    typedef enum logic [CFG_AW-1:0] {
        CFG_SLOPE  = 1'b0,
        CFG_OFFSET = 1'b1
    } cfg_idx_t;

    localparam logic signed [SLOPE_W-1:0]  SLOPE_RESET  = -24'sd1456;
    localparam logic signed [OFFSET_W-1:0] OFFSET_RESET = 32'sd9757082;

    // true modulo of the shift sum by the channel length (5 * 512):
    // low 9 bits pass, the block quotient is reduced mod 5 by nibble folding
    function automatic logic [IDX_W-1:0] shift_mod(input logic signed [TOTAL_W-1:0] total);
        logic        [SHIFT_LOW_W-1:0] low;
        logic signed [QUOT_W-1:0]      quot;
        logic        [QBIAS_W-1:0]     qb;
        logic        [5:0]             nib_sum;
        logic        [4:0]             fold;
        logic        [2:0]             m5;
        low     = total[SHIFT_LOW_W-1:0];
        quot    = total[TOTAL_W-1:SHIFT_LOW_W];
        qb      = QBIAS_W'(quot) + QBIAS_W'(QBIAS);
        nib_sum = 6'(qb[3:0]) + 6'(qb[7:4]) + 6'(qb[11:8]) + 6'(qb[15:12])
                + 6'(qb[17:16]);
        fold    = 5'(nib_sum[5:4]) + 5'(nib_sum[3:0]);
        if (fold >= 5'd15) begin
            m5 = 3'(fold - 5'd15);
        end else if (fold >= 5'd10) begin
            m5 = 3'(fold - 5'd10);
        end else if (fold >= 5'd5) begin
            m5 = 3'(fold - 5'd5);
        end else begin
            m5 = 3'(fold);
        end
        return {m5, low};
    endfunction

endpackage

`default_nettype wire

// ===== hdl/waveform_pedestal_align_peak.sv =====
// Pedestal subtraction, circular alignment and peak search for a 4-channel
// digitizer waveform.
// Input channel s_*: one item per operation; s_tuser selects pedestal load,
// event start or waveform sample, s_tlast marks the last sample of an event.
// Result channel m_*: m_tuser tells an aligned sample from the event peak
// summary, m_tlast marks the last result caused by one input item.
// Configuration: cfg_wen writes register cfg_addr (0 slope, 1 offset) with
// cfg_wdata; write it only while the block is idle.
// Samples and pedestal loads are taken one per cycle while s_tready is high. A
// sample passes the input stage, with its registered pedestal memory read,
// then subtraction, alignment and the peak compare into the output register.
// The last sample of an event produces two results, the aligned sample and then the peak summary.
// An event start holds s_tready low from its acceptance until the shift is
// committed, while it is worked out (vernier multiply, fine/coarse add, modulo
// by the channel length); a sample ahead of it has already left the input
// stage by then.
// When m_tready is low the output register holds its item; one more item
// is taken into the input stage, then s_tready drops.
// aresetn (synchronous) clears shift, peak tracker, valid flags and loads
// the register defaults; pedestal memory contents are kept.

`default_nettype none

module waveform_pedestal_align_peak (
    input  wire                              aclk,
    input  wire                              aresetn,
    // channel[1:0], sample_index[13:2], raw_value[29:14], trig_cell[37:30],
    // vernier[53:38], zero fill
    input  wire  [wpap_pkg::S_TDATA_W-1:0]   s_tdata,
    // operation[1:0]
    input  wire  [wpap_pkg::S_TUSER_W-1:0]   s_tuser,
    input  wire                              s_tlast,
    input  wire                              s_tvalid,
    output logic                             s_tready,
    // out_channel[1:0], position[13:2], value[26:14], zero fill
    output logic [wpap_pkg::M_TDATA_W-1:0]   m_tdata,
    // kind[0]
    output logic [wpap_pkg::M_TUSER_W-1:0]   m_tuser,
    output logic                             m_tlast,
    output logic                             m_tvalid,
    input  wire                              m_tready,
    input  wire                              cfg_wen,
    input  wire  [wpap_pkg::CFG_AW-1:0]      cfg_addr,
    input  wire  [wpap_pkg::CFG_DW-1:0]      cfg_wdata
);
    import wpap_pkg::*;

    // input field decode
    logic [CH_W-1:0]          in_channel;
    logic [IDX_W-1:0]         in_index_raw;
    logic [IDX_W-1:0]         in_index;
    logic [RAW_W-1:0]         in_raw;
    logic [CELL_W-1:0]        in_cell;
    logic signed [VERN_W-1:0] in_vern;
    logic [MEM_AW-1:0]        mem_addr;
    logic                     accept;
    logic                     acc_ped;
    logic                     acc_start;
    logic                     acc_sample;

    // configuration
    logic signed [SLOPE_W-1:0]  slope_reg;
    logic signed [OFFSET_W-1:0] offset_reg;

    // pedestal memory
    logic [ADC_W-1:0] ped_mem [MEM_DEPTH];
    logic [ADC_W-1:0] ped_rd_reg;

    // sample input stage
    logic             s1_vld_reg;
    logic             s1_vld_next;
    logic [CH_W-1:0]  s1_channel_reg;
    logic [IDX_W-1:0] s1_index_reg;
    logic [ADC_W-1:0] s1_raw_reg;
    logic             s1_final_reg;

    // event state
    logic [IDX_W-1:0]        shift_reg;
    logic signed [VAL_W-1:0] peak_value_reg;
    logic [CH_W-1:0]         peak_channel_reg;
    logic [IDX_W-1:0]        peak_pos_reg;
    logic [IDX_W-1:0]        peak_idx_reg;
    logic signed [VAL_W-1:0] peak_value_next;
    logic [CH_W-1:0]         peak_channel_next;
    logic [IDX_W-1:0]        peak_pos_next;
    logic [IDX_W-1:0]        peak_idx_next;

    // sample compute
    logic signed [VAL_W-1:0] smp_value;
    logic [IDX_W:0]          smp_diff;
    logic [IDX_W-1:0]        smp_pos;
    logic                    smp_take;

    // output register
    logic                    out_vld_reg;
    logic                    out_two_reg;
    logic                    out_beat_reg;
    logic [CH_W-1:0]         out_channel_reg;
    logic [IDX_W-1:0]        out_pos_reg;
    logic signed [VAL_W-1:0] out_value_reg;
    logic [CH_W-1:0]         out_pk_channel_reg;
    logic [IDX_W-1:0]        out_pk_pos_reg;
    logic signed [VAL_W-1:0] out_pk_value_reg;
    logic                    out_last_beat;
    logic                    adv;

    // start sequence
    logic                       st1_vld_reg;
    logic                       st2_vld_reg;
    logic                       st3_vld_reg;
    logic [CELL_W-1:0]          st_cell_reg;
    logic signed [VERN_W-1:0]   st_vern_reg;
    logic signed [PROD_W-1:0]   st_prod_reg;
    logic signed [PROD_W-1:0]   st_prod_next;
    logic signed [COARSE_W-1:0] st_coarse_reg;
    logic signed [COARSE_W-1:0] st_coarse_next;
    logic signed [CDIFF_W-1:0]  st_cdiff;
    logic signed [SUM_W-1:0]    st_sum;
    logic signed [FINE_W-1:0]   st_fine;
    logic                       st_round;
    logic signed [TOTAL_W-1:0]  st_total_reg;
    logic signed [TOTAL_W-1:0]  st_total_next;
    logic                       start_busy;
    logic                       commit;

    // unpack the input item and form the pedestal address
    always_comb begin
        in_channel   = s_tdata[1:0];
        in_index_raw = s_tdata[13:2];
        in_raw       = s_tdata[29:14];
        in_cell      = s_tdata[37:30];
        in_vern      = $signed(s_tdata[53:38]);
        if (in_index_raw >= IDX_W'(SAMPLES_PER_CHANNEL)) begin
            in_index = in_index_raw - IDX_W'(SAMPLES_PER_CHANNEL);
        end else begin
            in_index = in_index_raw;
        end
        mem_addr = MEM_AW'(in_channel) * MEM_AW'(SAMPLES_PER_CHANNEL) + MEM_AW'(in_index);
    end

    // handshake
    assign out_last_beat = !out_two_reg || out_beat_reg;
    assign adv           = !out_vld_reg || (m_tready && out_last_beat);
    assign start_busy    = st1_vld_reg || st2_vld_reg || st3_vld_reg;
    assign s_tready      = !start_busy && (!s1_vld_reg || adv);
    assign accept        = s_tvalid && s_tready;
    assign acc_ped       = accept && (s_tuser == OP_PEDESTAL);
    assign acc_start     = accept && (s_tuser == OP_START);
    assign acc_sample    = accept && (s_tuser == OP_SAMPLE);
    assign commit        = st3_vld_reg && !s1_vld_reg;

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            slope_reg  <= SLOPE_RESET;
            offset_reg <= OFFSET_RESET;
        end else if (cfg_wen) begin
            unique case (cfg_addr)
                CFG_SLOPE:  slope_reg  <= $signed(cfg_wdata[SLOPE_W-1:0]);
                CFG_OFFSET: offset_reg <= $signed(cfg_wdata[OFFSET_W-1:0]);
                default:    ;
            endcase
        end
    end

    // pedestal memory, one write or one read per cycle
    always_ff @(posedge aclk) begin
        if (acc_ped) begin
            ped_mem[mem_addr] <= in_raw[ADC_W-1:0];
        end
        if (acc_sample) begin
            ped_rd_reg <= ped_mem[mem_addr];
        end
    end

    // sample input stage
    always_comb begin
        if (acc_sample) begin
            s1_vld_next = 1'b1;
        end else if (adv) begin
            s1_vld_next = 1'b0;
        end else begin
            s1_vld_next = s1_vld_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_vld_reg <= 1'b0;
        end else begin
            s1_vld_reg <= s1_vld_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (acc_sample) begin
            s1_channel_reg <= in_channel;
            s1_index_reg   <= in_index;
            s1_raw_reg     <= in_raw[ADC_W-1:0];
            s1_final_reg   <= s_tlast;
        end
    end

    // subtract, align and compare against the held peak
    always_comb begin
        smp_value = $signed({1'b0, s1_raw_reg}) - $signed({1'b0, ped_rd_reg});
        smp_diff  = {1'b0, s1_index_reg} - {1'b0, shift_reg};
        if (smp_diff[IDX_W]) begin
            smp_pos = smp_diff[IDX_W-1:0] + IDX_W'(SAMPLES_PER_CHANNEL);
        end else begin
            smp_pos = smp_diff[IDX_W-1:0];
        end
        smp_take = 1'b0;
        if (smp_value > 0) begin
            if (smp_value > peak_value_reg) begin
                smp_take = 1'b1;
            end else if (smp_value == peak_value_reg) begin
                // tie: lower channel wins, then the earlier raw index
                smp_take = (s1_channel_reg < peak_channel_reg)
                        || (s1_channel_reg == peak_channel_reg
                            && s1_index_reg < peak_idx_reg);
            end
        end
        if (smp_take) begin
            peak_value_next   = smp_value;
            peak_channel_next = s1_channel_reg;
            peak_pos_next     = smp_pos;
            peak_idx_next     = s1_index_reg;
        end else begin
            peak_value_next   = peak_value_reg;
            peak_channel_next = peak_channel_reg;
            peak_pos_next     = peak_pos_reg;
            peak_idx_next     = peak_idx_reg;
        end
    end

    // event shift and peak tracker
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            shift_reg        <= '0;
            peak_value_reg   <= '0;
            peak_channel_reg <= '0;
            peak_pos_reg     <= '0;
            peak_idx_reg     <= '0;
        end else if (commit) begin
            shift_reg        <= shift_mod(st_total_reg);
            peak_value_reg   <= '0;
            peak_channel_reg <= '0;
            peak_pos_reg     <= '0;
            peak_idx_reg     <= '0;
        end else if (adv && s1_vld_reg) begin
            peak_value_reg   <= peak_value_next;
            peak_channel_reg <= peak_channel_next;
            peak_pos_reg     <= peak_pos_next;
            peak_idx_reg     <= peak_idx_next;
        end
    end

    // output register, a final sample is sent as two beats
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_vld_reg  <= 1'b0;
            out_beat_reg <= 1'b0;
        end else if (adv) begin
            out_vld_reg  <= s1_vld_reg;
            out_beat_reg <= 1'b0;
        end else if (m_tready) begin
            out_beat_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv && s1_vld_reg) begin
            out_two_reg        <= s1_final_reg;
            out_channel_reg    <= s1_channel_reg;
            out_pos_reg        <= smp_pos;
            out_value_reg      <= smp_value;
            out_pk_channel_reg <= peak_channel_next;
            out_pk_pos_reg     <= peak_pos_next;
            out_pk_value_reg   <= peak_value_next;
        end
    end

    // result item
    always_comb begin
        m_tvalid = out_vld_reg;
        m_tlast  = out_last_beat;
        m_tdata  = '0;
        if (out_beat_reg) begin
            m_tuser       = KIND_PEAK;
            m_tdata[1:0]  = out_pk_channel_reg;
            m_tdata[13:2] = out_pk_pos_reg;
            m_tdata[26:14] = out_pk_value_reg;
        end else begin
            m_tuser       = KIND_SAMPLE;
            m_tdata[1:0]  = out_channel_reg;
            m_tdata[13:2] = out_pos_reg;
            m_tdata[26:14] = out_value_reg;
        end
    end

    // start sequence: vernier product, coarse + truncated fine sum
    always_comb begin
        st_cdiff       = $signed(CDIFF_W'(NUM_CELLS)) - $signed({2'b00, st_cell_reg});
        st_coarse_next = COARSE_W'(32'(st_cdiff) * COARSE_STEP);
        st_prod_next   = PROD_W'(slope_reg) * PROD_W'(st_vern_reg);
        st_sum         = SUM_W'(offset_reg) + SUM_W'(st_prod_reg);
        st_fine        = st_sum[SUM_W-1:FRAC_W];
        // floor to truncation toward zero for negative sums
        st_round       = st_sum[SUM_W-1] && (st_sum[FRAC_W-1:0] != '0);
        st_total_next  = TOTAL_W'(st_coarse_reg) + TOTAL_W'(st_fine)
                       + $signed({{(TOTAL_W-1){1'b0}}, st_round});
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st1_vld_reg <= 1'b0;
            st2_vld_reg <= 1'b0;
            st3_vld_reg <= 1'b0;
        end else begin
            st1_vld_reg <= acc_start;
            st2_vld_reg <= st1_vld_reg;
            if (st2_vld_reg) begin
                st3_vld_reg <= 1'b1;
            end else if (commit) begin
                st3_vld_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (acc_start) begin
            st_cell_reg <= in_cell;
            st_vern_reg <= in_vern;
        end
        if (st1_vld_reg) begin
            st_prod_reg   <= st_prod_next;
            st_coarse_reg <= st_coarse_next;
        end
        if (st2_vld_reg) begin
            st_total_reg <= st_total_next;
        end
    end

endmodule

`default_nettype wire
